FILE: hdl/rau_pkg.sv
`timescale 1ns / 1ps
// rau_pkg: shared types, codes and widths of the rational arithmetic unit
// used by the channel interfaces, the controller, the datapath and the top level

package rau_pkg;

   localparam int unsigned OPERAND_BITS_DEF = 16;
   localparam int unsigned OPCODE_BITS      = 2;
   localparam int unsigned RES_NUM_BITS     = 32;
   localparam int unsigned RES_DEN_BITS     = 31;
   localparam int unsigned STATUS_BITS      = 2;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_BAD_DEN  = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mul;
      logic comb;
      logic sign;
      logic gcd_step;
      logic div_init;
      logic div_step;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic special;
      logic gcd_done;
   } stat_type;

endpackage

FILE: hdl/rau_req_if.sv
`timescale 1ns / 1ps
// rau_req_if: request channel of the rational arithmetic unit, valid/ready
// depends on rau_pkg for widths

interface rau_req_if #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
);
   logic                                   valid;
   logic                                   ready;
   logic        [rau_pkg::OPCODE_BITS-1:0] opcode;
   logic signed [OPERAND_BITS-1:0]         a_num;
   logic        [OPERAND_BITS-2:0]         a_den;
   logic signed [OPERAND_BITS-1:0]         b_num;
   logic        [OPERAND_BITS-2:0]         b_den;

   modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

FILE: hdl/rau_rsp_if.sv
`timescale 1ns / 1ps
// rau_rsp_if: response channel of the rational arithmetic unit, valid/ready
// depends on rau_pkg for widths

interface rau_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [rau_pkg::RES_NUM_BITS-1:0]  res_num;
   logic        [rau_pkg::RES_DEN_BITS-1:0]  res_den;
   logic        [rau_pkg::STATUS_BITS-1:0]   status;

   modport source (output valid, res_num, res_den, status, input ready);
   modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

FILE: hdl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// rational_arithmetic_unit: top level, fraction add/sub/mul/div reduced by gcd
// depends on rau_pkg, rau_req_if, rau_rsp_if, rau_ctrl and rau_datapath
//
//   channel  dir  handshake    word
//   req_if   in   valid/ready  opcode, a_num, a_den, b_num, b_den
//   rsp_if   out  valid/ready  res_num, res_den, status
//
// one word at a time; a word is loaded, its cross products are formed, combined and
// sign fixed, then it is reduced by a binary gcd of one subtract or shift per cycle
// and divided by the gcd with restoring division before the output is loaded
// a zero-denominator or divide-by-zero word skips the arithmetic
// the response sits in its own register, so the next word is taken while it waits
// synchronous active-high reset clears the sequencer and the response valid

module rational_arithmetic_unit #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   rau_req_if.sink    req_if,
   rau_rsp_if.source  rsp_if
);

   rau_pkg::cmd_type   cmd;
   rau_pkg::stat_type  stat;

   rau_ctrl #(.OPERAND_BITS(OPERAND_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rau_datapath #(.OPERAND_BITS(OPERAND_BITS)) u_datapath (
      .clock   (clock),
      .cmd     (cmd),
      .stat    (stat),
      .opcode  (req_if.opcode),
      .a_num   (req_if.a_num),
      .a_den   (req_if.a_den),
      .b_num   (req_if.b_num),
      .b_den   (req_if.b_den),
      .res_num (rsp_if.res_num),
      .res_den (rsp_if.res_den),
      .status  (rsp_if.status)
   );

endmodule

FILE: hdl/rau_ctrl.sv
`timescale 1ns / 1ps
// rau_ctrl: sequencer of the rational arithmetic unit and the response valid flag
// depends on rau_pkg for command and status structs

module rau_ctrl #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  rau_pkg::stat_type  stat,
   output rau_pkg::cmd_type   cmd
);

   localparam int W  = 2 * OPERAND_BITS + 1;
   localparam int CB = $clog2(W);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_COMB, S_SIGN, S_GCD, S_DINIT, S_DIV, S_FIN
   } state_type;

   state_type      state_ff, state_in;
   logic [CB-1:0]  cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = S_MUL;
         end
         S_MUL: begin
            // flagged items skip the arithmetic
            if (stat.special) begin
               state_in = S_FIN;
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_COMB;
            end
         end
         S_COMB: begin
            cmd.comb = 1'b1;
            state_in = S_SIGN;
         end
         S_SIGN: begin
            cmd.sign = 1'b1;
            state_in = S_GCD;
         end
         S_GCD: begin
            if (stat.gcd_done) state_in = S_DINIT;
            else cmd.gcd_step = 1'b1;
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = CB'(W - 1);
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) state_in = S_FIN;
            else cnt_in = cnt_ff - 1'b1;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten while held");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FIN))
      else $error("response raised outside finish");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == '0) |=> state_ff == S_FIN)
      else $error("division did not end on count");
`endif

endmodule

FILE: hdl/rau_datapath.sv
`timescale 1ns / 1ps
// rau_datapath: cross products, sign fix, binary gcd and two-lane restoring divide
// depends on rau_pkg for codes and command/status structs

module rau_datapath #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
   input  logic                                   clock,
   input  rau_pkg::cmd_type                       cmd,
   output rau_pkg::stat_type                      stat,
   input  logic        [rau_pkg::OPCODE_BITS-1:0] opcode,
   input  logic signed [OPERAND_BITS-1:0]         a_num,
   input  logic        [OPERAND_BITS-2:0]         a_den,
   input  logic signed [OPERAND_BITS-1:0]         b_num,
   input  logic        [OPERAND_BITS-2:0]         b_den,
   output logic signed [rau_pkg::RES_NUM_BITS-1:0] res_num,
   output logic        [rau_pkg::RES_DEN_BITS-1:0] res_den,
   output logic        [rau_pkg::STATUS_BITS-1:0]  status
);

   localparam int NB = OPERAND_BITS;
   localparam int PB = 2 * NB;
   localparam int W  = PB + 1;
   localparam int KB = $clog2(W + 1);

   rau_pkg::opcode_type   op_ff;
   rau_pkg::status_type   st_ff, st_in;
   logic signed [NB-1:0]  an_ff, bn_ff;
   logic        [NB-2:0]  ad_ff, bd_ff;
   logic signed [PB-1:0]  m0_ff, m1_ff, m2_ff;
   logic signed [NB-1:0]  adx, bdx, msel;
   logic signed [W-1:0]   m0w, m1w, n_ff, n_in, d_ff, d_in;
   logic                  neg_ff;
   logic        [W-1:0]   x_ff, x_in, y_ff, y_in, nm_ff, dm_ff;
   logic        [KB-1:0]  k_ff, k_in;
   logic        [W-1:0]   rn_ff, rd_ff, qn_ff, qd_ff;
   logic        [W-1:0]   rn_nx, rd_nx, qn_nx, qd_nx;
   logic signed [W:0]     snum;
   logic signed [rau_pkg::RES_NUM_BITS-1:0] res_num_ff;
   logic        [rau_pkg::RES_DEN_BITS-1:0] res_den_ff;
   logic        [rau_pkg::STATUS_BITS-1:0]  status_ff;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   function automatic logic [2*W-1:0] div_bit(input logic [W-1:0] r, input logic [W-1:0] q,
                                               input logic [W-1:0] dv);
      logic [W:0] t;
      logic [W:0] s;
      t = {r, q[W-1]};
      s = t - {1'b0, dv};
      if (t >= {1'b0, dv}) div_bit = {s[W-1:0], q[W-2:0], 1'b1};
      else                 div_bit = {t[W-1:0], q[W-2:0], 1'b0};
   endfunction

   always_comb begin
      if (a_den == '0 || b_den == '0)
         st_in = rau_pkg::ST_BAD_DEN;
      else if (rau_pkg::opcode_type'(opcode) == rau_pkg::OP_DIV && b_num == '0)
         st_in = rau_pkg::ST_DIV_ZERO;
      else
         st_in = rau_pkg::ST_OK;
   end

   assign adx  = $signed({1'b0, ad_ff});
   assign bdx  = $signed({1'b0, bd_ff});
   assign msel = (op_ff == rau_pkg::OP_MUL) ? bn_ff : bdx;
   assign m0w  = W'(m0_ff);
   assign m1w  = W'(m1_ff);

   always_comb begin
      unique case (op_ff)
         rau_pkg::OP_ADD: n_in = m0w + m1w;
         rau_pkg::OP_SUB: n_in = m0w - m1w;
         default:         n_in = m0w;
      endcase
      d_in = (op_ff == rau_pkg::OP_DIV) ? m1w : W'(m2_ff);
   end

   // binary gcd, common factors of two counted in k and put back at the end
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      k_in = k_ff;
      priority if (x_ff == '0) begin
         y_in = {y_ff[W-2:0], 1'b0};
         k_in = k_ff - 1'b1;
      end else if (!x_ff[0] && !y_ff[0]) begin
         x_in = x_ff >> 1;
         y_in = y_ff >> 1;
         k_in = k_ff + 1'b1;
      end else if (!x_ff[0]) begin
         x_in = x_ff >> 1;
      end else if (!y_ff[0]) begin
         y_in = y_ff >> 1;
      end else if (x_ff >= y_ff) begin
         x_in = x_ff - y_ff;
      end else begin
         y_in = y_ff - x_ff;
      end
   end

   assign {rn_nx, qn_nx} = div_bit(rn_ff, qn_ff, y_ff);
   assign {rd_nx, qd_nx} = div_bit(rd_ff, qd_ff, y_ff);

   assign snum = neg_ff ? -$signed({1'b0, qn_ff}) : $signed({1'b0, qn_ff});

   assign stat.special  = (st_ff != rau_pkg::ST_OK);
   assign stat.gcd_done = (x_ff == '0) && (k_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= rau_pkg::opcode_type'(opcode);
         st_ff <= st_in;
         an_ff <= a_num;
         ad_ff <= a_den;
         bn_ff <= b_num;
         bd_ff <= b_den;
      end
      if (cmd.mul) begin
         m0_ff <= an_ff * msel;
         m1_ff <= adx * bn_ff;
         m2_ff <= adx * bdx;
      end
      if (cmd.comb) begin
         n_ff <= n_in;
         d_ff <= d_in;
      end
      if (cmd.sign) begin
         neg_ff <= n_ff[W-1] ^ d_ff[W-1];
         x_ff   <= n_ff[W-1] ? W'(-n_ff) : W'(n_ff);
         y_ff   <= d_ff[W-1] ? W'(-d_ff) : W'(d_ff);
         nm_ff  <= n_ff[W-1] ? W'(-n_ff) : W'(n_ff);
         dm_ff  <= d_ff[W-1] ? W'(-d_ff) : W'(d_ff);
         k_ff   <= '0;
      end
      if (cmd.gcd_step) begin
         x_ff <= x_in;
         y_ff <= y_in;
         k_ff <= k_in;
      end
      if (cmd.div_init) begin
         rn_ff <= '0;
         rd_ff <= '0;
         qn_ff <= nm_ff;
         qd_ff <= dm_ff;
      end
      if (cmd.div_step) begin
         rn_ff <= rn_nx;
         rd_ff <= rd_nx;
         qn_ff <= qn_nx;
         qd_ff <= qd_nx;
      end
      if (cmd.out_load) begin
         if (st_ff != rau_pkg::ST_OK) begin
            res_num_ff <= rau_pkg::RES_NUM_BITS'(1);
            res_den_ff <= rau_pkg::RES_DEN_BITS'(1);
         end else begin
            res_num_ff <= rau_pkg::RES_NUM_BITS'(snum);
            res_den_ff <= rau_pkg::RES_DEN_BITS'(qd_ff);
         end
         status_ff <= st_ff;
      end
   end

   assign res_num = res_num_ff;
   assign res_den = res_den_ff;
   assign status  = status_ff;

endmodule

FILE: verif/rau_checker.sv
`timescale 1ns / 1ps
// rau_checker: watches the request and response channels of the rational arithmetic unit,
// predicts each reduced fraction and compares it; depends on rau_pkg, rau_req_if, rau_rsp_if

module rau_checker (
   input  logic        clock,
   input  logic        reset,
   rau_req_if          req_mon,
   rau_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending,
   output int unsigned checked_count
);

   typedef struct packed {
      logic signed [rau_pkg::RES_NUM_BITS-1:0] num;
      logic        [rau_pkg::RES_DEN_BITS-1:0] den;
      rau_pkg::status_type                     status;
   } fraction_type;

   fraction_type reduced_q[$];

   function automatic fraction_type reduce_fraction(rau_pkg::opcode_type op,
                                                    logic signed [15:0] an,
                                                    logic [14:0] ad, logic signed [15:0] bn,
                                                    logic [14:0] bd);
      fraction_type r;
      longint n, d, x, y, t;
      r.num = rau_pkg::RES_NUM_BITS'(1);
      r.den = rau_pkg::RES_DEN_BITS'(1);
      r.status = rau_pkg::ST_OK;
      if (ad == 0 || bd == 0) begin
         r.status = rau_pkg::ST_BAD_DEN;
         return r;
      end
      if (op == rau_pkg::OP_DIV && bn == 0) begin
         r.status = rau_pkg::ST_DIV_ZERO;
         return r;
      end
      case (op)
         rau_pkg::OP_ADD: begin
            n = longint'(an) * longint'(bd) + longint'(ad) * longint'(bn);
            d = longint'(ad) * longint'(bd);
         end
         rau_pkg::OP_SUB: begin
            n = longint'(an) * longint'(bd) - longint'(ad) * longint'(bn);
            d = longint'(ad) * longint'(bd);
         end
         rau_pkg::OP_MUL: begin
            n = longint'(an) * longint'(bn);
            d = longint'(ad) * longint'(bd);
         end
         default: begin
            n = longint'(an) * longint'(bd);
            d = longint'(ad) * longint'(bn);
         end
      endcase
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      x = (n < 0) ? -n : n;
      y = d;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      r.num = rau_pkg::RES_NUM_BITS'(n / x);
      r.den = rau_pkg::RES_DEN_BITS'(d / x);
      return r;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("%0t checker: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   assign pending = reduced_q.size();

   initial begin
      fail_count = 0;
      checked_count = 0;
   end

   always @(posedge clock) begin
      fraction_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            reduced_q.push_back(reduce_fraction(rau_pkg::opcode_type'(req_mon.opcode),
                                                req_mon.a_num, req_mon.a_den,
                                                req_mon.b_num, req_mon.b_den));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (reduced_q.size() == 0) begin
               $display("%0t checker: response word with nothing expected", $realtime);
               fail_count++;
            end else begin
               want = reduced_q.pop_front();
               checked_count++;
               if (rsp_mon.res_num !== want.num) report("res_num", rsp_mon.res_num, want.num);
               if (rsp_mon.res_den !== want.den) report("res_den", rsp_mon.res_den, want.den);
               if (rsp_mon.status !== want.status) report("status", rsp_mon.status, want.status);
            end
         end
      end
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// tb: drives directed and random fraction words into the rational arithmetic unit
// with random idling and one long response stall; depends on rau_pkg, the channel
// interfaces, rational_arithmetic_unit and rau_checker

module tb;

   logic        clock = 0;
   logic        reset = 1;
   int unsigned fail_count, pending, checked_count;
   int unsigned sent = 0;
   bit          steady = 0;   // no idling on either side
   int          hold_cycles = 0;
   bit          hold_done = 0;
   int unsigned cnt_op[4] = '{0, 0, 0, 0};

   rau_req_if #(.OPERAND_BITS(16)) req_if ();
   rau_rsp_if                      rsp_if ();

   rational_arithmetic_unit #(.OPERAND_BITS(16)) i_dut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source)
   );

   rau_checker i_checker (
      .clock(clock), .reset(reset), .req_mon(req_if), .rsp_mon(rsp_if),
      .fail_count(fail_count), .pending(pending), .checked_count(checked_count)
   );

   always #10 clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.opcode = rau_pkg::OP_ADD;
      req_if.a_num = '0;
      req_if.a_den = 15'd1;
      req_if.b_num = '0;
      req_if.b_den = 15'd1;
   end

   task automatic send_word(rau_pkg::opcode_type op, logic signed [15:0] an, logic [14:0] ad,
                            logic signed [15:0] bn, logic [14:0] bd);
      if (!steady && $urandom_range(99) < 19) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.opcode <= op;
      req_if.a_num  <= an;
      req_if.a_den  <= ad;
      req_if.b_num  <= bn;
      req_if.b_den  <= bd;
      do @(posedge clock); while (!req_if.ready);
      sent++;
      cnt_op[op]++;
   endtask

   function automatic logic signed [15:0] rand_num();
      case ($urandom_range(3))
         0: return 16'(int'($urandom_range(0, 20)) - 10);
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [14:0] rand_den();
      case ($urandom_range(15))
         0: return '0;
         1: return 15'h7fff;
         2, 3, 4: return 15'($urandom_range(1, 12));
         default: return 15'($urandom_range(1, 32767));
      endcase
   endfunction

   // response side: random back-pressure, plus one long hold-off while the sender keeps offering
   always @(posedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else if (hold_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (!hold_done && sent >= 320) begin
         rsp_if.ready <= 1'b0;
         hold_done <= 1'b1;
         hold_cycles <= 3000;
      end else
         rsp_if.ready <= steady || ($urandom_range(99) >= 19);
   end

   initial begin
      #40ms;
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      rau_pkg::opcode_type op;
      logic signed [15:0] x;
      int waited;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every operation, special cases
      for (int k = 0; k < 4; k++) begin
         op = rau_pkg::opcode_type'(k);
         send_word(op, 16'sh7fff, 15'd1, 16'sh7fff, 15'd1);
         send_word(op, 16'sh8000, 15'h7fff, 16'sh8000, 15'h7fff);
         send_word(op, 16'sh8000, 15'd1, 16'sh7fff, 15'h7fff);
      end
      send_word(rau_pkg::OP_ADD, 16'sd0, 15'h7fff, 16'sd0, 15'd3);   // zero result is 0/1
      send_word(rau_pkg::OP_SUB, 16'sd5, 15'd7, 16'sd5, 15'd7);
      send_word(rau_pkg::OP_DIV, 16'sd3, 15'd4, 16'sd0, 15'd9);      // divide by zero fraction
      send_word(rau_pkg::OP_DIV, 16'sd3, 15'd0, 16'sd0, 15'd9);      // bad den wins
      send_word(rau_pkg::OP_MUL, 16'sd3, 15'd5, 16'sd2, 15'd0);
      send_word(rau_pkg::OP_ADD, 16'sd0, 15'd0, 16'sd0, 15'd0);
      send_word(rau_pkg::OP_DIV, 16'sd6, 15'd4, -16'sd3, 15'd8);     // negative divisor
      send_word(rau_pkg::OP_DIV, -16'sd6, 15'd4, -16'sd3, 15'd8);
      send_word(rau_pkg::OP_MUL, 16'sd12, 15'd18, 16'sd3, 15'd2);    // 1/1 after reduction
      send_word(rau_pkg::OP_ADD, 16'sd1, 15'd2, 16'sd1, 15'd2);

      for (int i = 0; i < 1525; i++) begin
         steady = (i >= 700 && i < 850);
         x = rand_num();
         op = rau_pkg::opcode_type'($urandom_range(3));
         send_word(op, x, rand_den(), ($urandom_range(19) == 0) ? 16'sd0 : rand_num(),
                   rand_den());
      end
      req_if.valid <= 1'b0;

      waited = 0;
      while (pending != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (400) @(posedge clock);

      $display("tb: %0d words sent, %0d responses checked", sent, checked_count);
      $display("tb: add %0d, sub %0d, mul %0d, div %0d", cnt_op[0], cnt_op[1], cnt_op[2],
               cnt_op[3]);
      if (fail_count == 0 && pending == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
